// File: hdl/wfg_pkg.sv
// ----------------------------------------------------------------------------
// wfg_pkg: shared types and constants of the waveform function generator
// Register map codes, shape codes, noise LFSR constants, queue entry and
// configuration types, and elaboration-time helpers for the sine and LFSR
// tables.
// ----------------------------------------------------------------------------
package wfg_pkg;

	// register indexes (byte address = 4 * index)
	localparam int CFG_ADDR_W = 5;
	localparam logic [2:0] REG_WAVE_SHAPE    = 3'd0;
	localparam logic [2:0] REG_PHASE_STEP    = 3'd1;
	localparam logic [2:0] REG_START_PHASE   = 3'd2;
	localparam logic [2:0] REG_AMPLITUDE     = 3'd3;
	localparam logic [2:0] REG_DC_OFFSET     = 3'd4;
	localparam logic [2:0] REG_NOISE_PERCENT = 3'd5;

	// register reset values
	localparam logic [2:0]  RST_WAVE_SHAPE    = 3'd0;
	localparam logic [31:0] RST_PHASE_STEP    = 32'd85899346;
	localparam logic [15:0] RST_START_PHASE   = 16'd0;
	localparam logic [14:0] RST_AMPLITUDE     = 15'd10813;
	localparam logic [15:0] RST_DC_OFFSET     = 16'd0;
	localparam logic [5:0]  RST_NOISE_PERCENT = 6'd0;

	// shape codes
	localparam logic [2:0] SHAPE_SINE     = 3'd0;
	localparam logic [2:0] SHAPE_SQUARE   = 3'd1;
	localparam logic [2:0] SHAPE_TRIANGLE = 3'd2;
	localparam logic [2:0] SHAPE_SAWTOOTH = 3'd3;
	localparam logic [2:0] SHAPE_NOISE    = 3'd4;

	// noise generator: 32-bit Galois LFSR, 16 shifts per draw
	localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED  = 32'hACE1_ACE1;
	localparam int          DRAW_STEPS = 16;

	// overlay size = round(amplitude * pct / 100), divide by reciprocal
	localparam logic [5:0]  PCT_MAX     = 6'd50;
	localparam logic [20:0] PCT_ROUND   = 21'd50;
	localparam logic [21:0] RECIP_100   = 22'd2684355;
	localparam int          RECIP_SHIFT = 28;

	// sine table build: pi/2 in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// depth of the front-to-back queue (power of two)
	localparam int Q_DEPTH = 4;

	typedef struct packed {
		logic [2:0]  wave_shape;
		logic [31:0] phase_step;
		logic [15:0] start_phase;
		logic [14:0] amplitude;
		logic [15:0] dc_offset;
		logic [5:0]  noise_percent;
	} cfg_t;

	typedef struct packed {
		logic [15:0] h;
		logic [15:0] r_shape;
		logic [15:0] r_ovl;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// quarter-wave entry i: round(32768 * sin(pi/2 * (i + 1/2) / 2^tab_bits))
	// seven series terms, term k divided by (2k)(2k+1)
	function automatic logic [16:0] sine_entry(int tab_bits, int i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned acc;
		x = (HALF_PI_Q30 * (64'd2 * longint'(i) + 64'd1)) >> (tab_bits + 1);
		x2 = (x * x) >> 30;
		acc = x;
		term = ((x * x2) >> 30) / 64'd6;
		acc = acc - term;
		term = ((term * x2) >> 30) / 64'd20;
		acc = acc + term;
		term = ((term * x2) >> 30) / 64'd42;
		acc = acc - term;
		term = ((term * x2) >> 30) / 64'd72;
		acc = acc + term;
		term = ((term * x2) >> 30) / 64'd110;
		acc = acc - term;
		term = ((term * x2) >> 30) / 64'd156;
		acc = acc + term;
		term = ((term * x2) >> 30) / 64'd210;
		acc = acc - term;
		return 17'((acc * 64'd32768 + (64'd1 << 29)) >> 30);
	endfunction

	// state of the LFSR after a number of shifts (constant arguments only)
	function automatic logic [31:0] lfsr_advance(logic [31:0] seed, int steps);
		logic [31:0] s;
		logic lsb;
		s = seed;
		for (int k = 0; k < steps; k++) begin
			lsb = s[0];
			s = s >> 1;
			if (lsb)
				s = s ^ LFSR_MASK;
		end
		return s;
	endfunction

endpackage

// File: hdl/waveform_function_generator.sv
// ----------------------------------------------------------------------------
// waveform_function_generator: DDS function generator, top level
// Register file on an APB-style port, front part (phase and noise), queue,
// and back part (shape, scaling, offset, overlay, saturation).
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one transaction per sample tick, s_tdata[0] = restart
//   (clears the phase accumulator before this sample).
//   Master stream: one transaction per tick, m_tdata holds the sample
//   (two's complement, SAMPLE_BITS wide, 10 V full scale), m_tuser[0] the
//   saturation flag.
//   Throughput: one sample per clock while m_tready stays high. Path: the
//   input transaction is queued, then read together with the table lookup,
//   then passes the shape, multiply and sum stages.
//   Stall: when m_tready is low the back pipeline holds its result; the
//   4-entry queue keeps absorbing ticks and s_tready drops once it is full.
//   Reset: registers return to their defaults, accumulator to zero, noise
//   LFSR to its seed; no flush pass, ready right after reset.
//   Configuration: write registers only while no tick is in flight.
//   Registers at byte address 4*i: wave_shape, phase_step, start_phase,
//   amplitude, dc_offset, noise_percent.
// ----------------------------------------------------------------------------
module waveform_function_generator #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample ticks
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [0] restart, [7:1] zero
	// samples
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,   // [SAMPLE_BITS-1:0] sample
	output logic [0:0]                        m_tuser,   // [0] clipped
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wfg_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import wfg_pkg::*;

	logic [2:0]  wave_shape_q;
	logic [31:0] phase_step_q;
	logic [15:0] start_phase_q;
	logic [14:0] amplitude_q;
	logic [15:0] dc_offset_q;
	logic [5:0]  noise_percent_q;
	logic [2:0]  reg_idx;
	logic        cfg_wr;

	cfg_t        cfg;
	q_stat_t     q_stat;
	q_entry_t    q_in;
	q_entry_t    q_head;
	logic        q_push;
	logic        q_pop;

	// APB decode
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q    <= RST_WAVE_SHAPE;
			phase_step_q    <= RST_PHASE_STEP;
			start_phase_q   <= RST_START_PHASE;
			amplitude_q     <= RST_AMPLITUDE;
			dc_offset_q     <= RST_DC_OFFSET;
			noise_percent_q <= RST_NOISE_PERCENT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WAVE_SHAPE:    wave_shape_q    <= pwdata[2:0];
				REG_PHASE_STEP:    phase_step_q    <= pwdata;
				REG_START_PHASE:   start_phase_q   <= pwdata[15:0];
				REG_AMPLITUDE:     amplitude_q     <= pwdata[14:0];
				REG_DC_OFFSET:     dc_offset_q     <= pwdata[15:0];
				REG_NOISE_PERCENT: noise_percent_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_WAVE_SHAPE:    prdata = 32'(wave_shape_q);
			REG_PHASE_STEP:    prdata = phase_step_q;
			REG_START_PHASE:   prdata = 32'(start_phase_q);
			REG_AMPLITUDE:     prdata = 32'(amplitude_q);
			REG_DC_OFFSET:     prdata = 32'(dc_offset_q);
			REG_NOISE_PERCENT: prdata = 32'(noise_percent_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.wave_shape    = wave_shape_q;
	assign cfg.phase_step    = phase_step_q;
	assign cfg.start_phase   = start_phase_q;
	assign cfg.amplitude     = amplitude_q;
	assign cfg.dc_offset     = dc_offset_q;
	assign cfg.noise_percent = noise_percent_q;

	// front: phase accumulator and noise draws
	wfg_front #(
		.PHASE_BITS (PHASE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_entry  (q_in)
	);

	// queue between front and back
	wfg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.pop    (q_pop),
		.dout   (q_head),
		.stat   (q_stat)
	);

	// back: shape, scaling and output
	wfg_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_stat   (q_stat),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// File: hdl/wfg_queue.sv
// ----------------------------------------------------------------------------
// wfg_queue: short FIFO between the front and back parts
// Holds classified phase and noise transactions so the front can keep
// accepting while the back is stalled by the output.
// ----------------------------------------------------------------------------
module wfg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wfg_pkg::q_entry_t  din,
	input  logic               pop,
	output wfg_pkg::q_entry_t  dout,
	output wfg_pkg::q_stat_t   stat
);
	import wfg_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	q_entry_t           mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	// status and head of queue
	assign stat.full  = (count_q == CNT_W'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign dout       = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop) else $error("queue read while empty");
`endif

endmodule

// File: hdl/wfg_front.sv
// ----------------------------------------------------------------------------
// wfg_front: input side of the waveform function generator
// Accepts sample ticks, runs the phase accumulator and the noise LFSR, and
// pushes the phase and noise draws of each tick into the queue.
// ----------------------------------------------------------------------------
module wfg_front #(
	parameter int PHASE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wfg_pkg::cfg_t      cfg,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [0] restart, [7:1] zero
	input  wfg_pkg::q_stat_t   q_stat,
	output logic               q_push,
	output wfg_pkg::q_entry_t  q_entry
);
	import wfg_pkg::*;

	logic [PHASE_BITS-1:0] acc_q;
	logic [PHASE_BITS-1:0] acc_base;
	logic [PHASE_BITS-1:0] phase;
	logic [31:0]           lfsr_q;
	logic [31:0]           lfsr_d;
	logic [31:0]           draw_one;
	logic [31:0]           draw_two;
	logic [31:0]           col_one [32];
	logic [31:0]           col_two [32];
	logic                  accept;
	logic                  is_noise;
	logic                  ovl_on;

	// one and two noise draws as constant XOR maps of the LFSR state
	for (genvar j = 0; j < 32; j++) begin : g_cols
		assign col_one[j] = lfsr_advance(32'd1 << j, DRAW_STEPS);
		assign col_two[j] = lfsr_advance(32'd1 << j, 2 * DRAW_STEPS);
	end

	always_comb begin
		draw_one = '0;
		draw_two = '0;
		for (int j = 0; j < 32; j++) begin
			draw_one = draw_one ^ ({32{lfsr_q[j]}} & col_one[j]);
			draw_two = draw_two ^ ({32{lfsr_q[j]}} & col_two[j]);
		end
	end

	// handshake
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept;

	// phase of this tick
	assign acc_base = s_tdata[0] ? '0 : acc_q;
	assign phase    = acc_base + (PHASE_BITS'(cfg.start_phase) << (PHASE_BITS - 16));

	// classify: which draws this tick takes
	assign is_noise = (cfg.wave_shape == SHAPE_NOISE);
	assign ovl_on   = (cfg.noise_percent != '0);

	assign q_entry.h       = phase[PHASE_BITS-1 -: 16];
	assign q_entry.r_shape = draw_one[15:0];
	assign q_entry.r_ovl   = is_noise ? draw_two[15:0] : draw_one[15:0];

	always_comb begin
		if (is_noise && ovl_on)
			lfsr_d = draw_two;
		else if (is_noise || ovl_on)
			lfsr_d = draw_one;
		else
			lfsr_d = lfsr_q;
	end

	// accumulator advance per accepted transaction; LFSR advance by the draws it takes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			lfsr_q <= LFSR_SEED;
		end else if (accept) begin
			acc_q  <= acc_base + PHASE_BITS'(cfg.phase_step);
			lfsr_q <= lfsr_d;
		end
	end

`ifndef SYNTHESIS
	a_lfsr_alive: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0) else $error("noise LFSR locked at zero");
`endif

endmodule

// File: hdl/wfg_back.sv
// ----------------------------------------------------------------------------
// wfg_back: output side of the waveform function generator
// Four-stage pipeline: sine table read, shape forming, amplitude scaling,
// offset and overlay sum with saturation and requantization.
// ----------------------------------------------------------------------------
module wfg_back #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wfg_pkg::cfg_t                       cfg,
	input  wfg_pkg::q_stat_t                    q_stat,
	input  wfg_pkg::q_entry_t                   q_head,
	output logic                                q_pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // [SAMPLE_BITS-1:0] sample
	output logic [0:0]                          m_tuser   // [0] clipped
);
	import wfg_pkg::*;

	localparam int TAB_N    = 1 << SINE_TABLE_BITS;
	localparam int TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int UP_SHIFT = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
	localparam int DN_SHIFT = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

	logic [16:0]                 sine_rom [TAB_N];
	logic [SINE_TABLE_BITS-1:0]  idx_raw;
	logic [SINE_TABLE_BITS-1:0]  rom_idx;
	logic                        en;

	logic                        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [15:0]                 h_s1;
	logic [15:0]                 r_shape_s1;
	logic [15:0]                 r_ovl_s1;
	logic [16:0]                 tab_s1;
	logic signed [17:0]          shape_s2;
	logic signed [31:0]          ovl_prod_s2;
	logic signed [32:0]          prod_s3;
	logic signed [31:0]          ovl_prod_s3;
	logic [SAMPLE_BITS-1:0]      sample_s4;
	logic                        clip_s4;

	logic [5:0]                  pct_c;
	logic [20:0]                 size_prod_q;
	logic [14:0]                 size_q;

	logic signed [17:0]          shape_d;
	logic signed [17:0]          two_h;
	logic signed [17:0]          tab_pos;
	logic signed [32:0]          scaled_w;
	logic signed [31:0]          ovl_w;
	logic signed [19:0]          sum;
	logic signed [15:0]          sat;
	logic                        clip_d;
	logic [SAMPLE_BITS-1:0]      sample_d;

	// quarter-wave sine table, built at elaboration
	for (genvar i = 0; i < TAB_N; i++) begin : g_rom
		assign sine_rom[i] = sine_entry(SINE_TABLE_BITS, i);
	end

	// pipeline advances unless the output holds an untaken result
	assign en    = !vld_s4 || m_tready;
	assign q_pop = en && !q_stat.empty;

	// table address, mirrored in the odd quarters
	assign idx_raw = q_head.h[13 -: SINE_TABLE_BITS];
	assign rom_idx = q_head.h[14] ? ~idx_raw : idx_raw;

	// overlay size from amplitude and percent (the user keeps config static while busy; not enforced here)
	assign pct_c = (cfg.noise_percent > PCT_MAX) ? PCT_MAX : cfg.noise_percent;

	always_ff @(posedge clk) begin
		size_prod_q <= 21'(cfg.amplitude) * 21'(pct_c) + PCT_ROUND;
		size_q      <= 15'((43'(size_prod_q) * 43'(RECIP_100)) >> RECIP_SHIFT);
	end

	// shape forming
	assign two_h   = $signed({1'b0, h_s1, 1'b0});
	assign tab_pos = $signed({1'b0, tab_s1});

	always_comb begin
		case (cfg.wave_shape)
			SHAPE_SINE:     shape_d = h_s1[15] ? -tab_pos : tab_pos;
			SHAPE_SQUARE:   shape_d = h_s1[15] ? -18'sd32768 : 18'sd32768;
			SHAPE_TRIANGLE: begin
				if (h_s1 < 16'd16384)
					shape_d = two_h;
				else if (h_s1 < 16'd49152)
					shape_d = 18'sd65536 - two_h;
				else
					shape_d = $signed({h_s1[15], h_s1, 1'b0});
			end
			SHAPE_SAWTOOTH: shape_d = 18'($signed(h_s1));
			SHAPE_NOISE:    shape_d = 18'($signed(r_shape_s1));
			default:        shape_d = '0;
		endcase
	end

	// rounding, offset, overlay and saturation
	assign scaled_w = (prod_s3 + 33'sd16384) >>> 15;
	assign ovl_w    = (ovl_prod_s3 + 32'sd16384) >>> 15;
	assign sum      = 20'(scaled_w) + 20'($signed(cfg.dc_offset)) + 20'(ovl_w);

	always_comb begin
		clip_d = 1'b0;
		if (sum > 20'sd32767) begin
			sat    = 16'sh7FFF;
			clip_d = 1'b1;
		end else if (sum < -20'sd32768) begin
			sat    = -16'sh8000;
			clip_d = 1'b1;
		end else begin
			sat = 16'(sum);
		end
	end

	// requantize to the output width
	if (SAMPLE_BITS >= 16) begin : g_up
		assign sample_d = SAMPLE_BITS'(sat) << UP_SHIFT;
	end else begin : g_dn
		assign sample_d = SAMPLE_BITS'(sat >>> DN_SHIFT);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= q_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			h_s1        <= q_head.h;
			r_shape_s1  <= q_head.r_shape;
			r_ovl_s1    <= q_head.r_ovl;
			tab_s1      <= sine_rom[rom_idx];
			shape_s2    <= shape_d;
			ovl_prod_s2 <= $signed(r_ovl_s1) * $signed({1'b0, size_q});
			prod_s3     <= shape_s2 * $signed({1'b0, cfg.amplitude});
			ovl_prod_s3 <= ovl_prod_s2;
			sample_s4   <= sample_d;
			clip_s4     <= clip_d;
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = TDATA_W'(sample_s4);
	assign m_tuser  = clip_s4;

`ifndef SYNTHESIS
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !m_tready) |-> !q_pop) else $error("queue popped during output stall");
`endif

endmodule
